FILE: src/hfdb_pkg.sv
// ----------------------------------------------------------------------------
// hfdb_pkg
// Shared types and constants of the host frame to DMX bridge: frame bytes,
// command codes, reply codes, result kinds and parser phases.
// ----------------------------------------------------------------------------
package hfdb_pkg;

  // Host frame bytes
  localparam logic [7:0] ByteStart  = 8'h5A;
  localparam logic [7:0] ByteEnd    = 8'hA5;
  localparam logic [7:0] Cmd96      = 8'hA0;
  localparam logic [7:0] Cmd256     = 8'hA1;
  localparam logic [7:0] Cmd512     = 8'hA2;
  localparam logic [7:0] ReplyError = 8'hC0;
  localparam logic [7:0] ReplyAck   = 8'hC1;

  // Channel counts carried by the commands (10 bits holds 512)
  localparam int unsigned     CountW   = 10;
  localparam logic [CountW-1:0] Count96  = 10'd96;
  localparam logic [CountW-1:0] Count256 = 10'd256;
  localparam logic [CountW-1:0] Count512 = 10'd512;

  localparam int unsigned MaxSlotsDefault = 512;

  // Timer reload after reset
  localparam logic [7:0] TimeoutReset = 8'd10;

  // Configuration register indexes
  localparam logic CfgTimeoutTicks = 1'b0;
  localparam logic CfgIdleReports  = 1'b1;

  // Input selector
  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  // Parser phase
  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhCmd   = 2'd1,
    PhSlots = 2'd2,
    PhEnd   = 2'd3
  } phase_e;

  // Result kind
  typedef enum logic [1:0] {
    KindBreak = 2'd0,
    KindSlot  = 2'd1,
    KindReply = 2'd2
  } kind_e;

  // Beat positions inside a three-byte reply
  localparam logic [1:0] BeatStart = 2'd0;
  localparam logic [1:0] BeatCode  = 2'd1;
  localparam logic [1:0] BeatEnd   = 2'd2;

endpackage

FILE: src/host_frame_to_dmx_bridge.sv
// ----------------------------------------------------------------------------
// host_frame_to_dmx_bridge
// Parses framed host bytes and timer ticks into DMX break requests, DMX slot
// bytes and three-byte host replies.
// ----------------------------------------------------------------------------
// Each accepted input transfer (host byte or timer tick) updates the parser and
// leaves its results in a single output register. After a transfer with no
// result or one result (break request or slot byte), bytes and ticks can stream
// at one per cycle while the result stream does not stall. A transfer that ends
// a frame yields a reply of three output beats (0x5A, ACK 0xC1 or ERROR 0xC0,
// 0xA5); the output register holds it until all three are taken, and the next
// transfer is taken in the same cycle as the final beat. tlast marks the final
// result of each input transfer. Configuration writes are always ready and
// take effect for the timer at its next reload.
module host_frame_to_dmx_bridge #(
  parameter int unsigned MaxSlots = hfdb_pkg::MaxSlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  // Input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  logic       s_axis_tuser_i,   // [0] action (0 byte, 1 tick)

  // Result stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] value
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o,

  // Configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned SlotW = $clog2(MaxSlots + 1);

  // Configuration registers
  logic [7:0] timeout_ticks_q;
  logic       idle_reports_q;

  // Parser state
  hfdb_pkg::phase_e phase_q, phase_d;
  logic [SlotW-1:0] slots_q, slots_d;
  logic [7:0]       ticks_q, ticks_d;

  // Result register
  logic            res_valid_q;
  hfdb_pkg::kind_e res_kind_q;
  logic [7:0]      res_value_q;
  logic [1:0]      beat_q;

  // Step outputs
  logic              emit;
  hfdb_pkg::kind_e   emit_kind;
  logic [7:0]        emit_value;
  logic [hfdb_pkg::CountW-1:0] cmd_count;
  logic              cmd_ok;
  logic [SlotW-1:0]  cmd_slots;

  logic in_fire, out_fire, out_last;

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= hfdb_pkg::TimeoutReset;
      idle_reports_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        hfdb_pkg::CfgTimeoutTicks: timeout_ticks_q <= cfg_data_i;
        hfdb_pkg::CfgIdleReports:  idle_reports_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Command decode and channel cap
  always_comb begin
    cmd_ok    = 1'b1;
    cmd_count = hfdb_pkg::Count96;
    unique case (s_axis_tdata_i)
      hfdb_pkg::Cmd96:  cmd_count = hfdb_pkg::Count96;
      hfdb_pkg::Cmd256: cmd_count = hfdb_pkg::Count256;
      hfdb_pkg::Cmd512: cmd_count = hfdb_pkg::Count512;
      default:          cmd_ok    = 1'b0;
    endcase
    if (32'(cmd_count) > MaxSlots) begin
      cmd_slots = SlotW'(MaxSlots);
    end else begin
      cmd_slots = SlotW'(cmd_count);
    end
  end

  // Parser next state for one input transfer
  always_comb begin
    phase_d = phase_q;
    slots_d = slots_q;
    ticks_d = timeout_ticks_q;
    if (s_axis_tuser_i == hfdb_pkg::ActTick) begin
      if (ticks_q > 8'd1) begin
        ticks_d = ticks_q - 8'd1;
      end else if (phase_q != hfdb_pkg::PhIdle || idle_reports_q) begin
        // timeout: frame dropped
        phase_d = hfdb_pkg::PhIdle;
      end
    end else begin
      unique case (phase_q)
        hfdb_pkg::PhIdle: begin
          if (s_axis_tdata_i == hfdb_pkg::ByteStart) begin
            phase_d = hfdb_pkg::PhCmd;
          end
        end
        hfdb_pkg::PhCmd: begin
          if (cmd_ok) begin
            slots_d = cmd_slots;
            phase_d = (cmd_slots == '0) ? hfdb_pkg::PhEnd : hfdb_pkg::PhSlots;
          end else begin
            phase_d = hfdb_pkg::PhIdle;
          end
        end
        hfdb_pkg::PhSlots: begin
          if (slots_q > SlotW'(1)) begin
            slots_d = slots_q - SlotW'(1);
          end else begin
            slots_d = '0;
            phase_d = hfdb_pkg::PhEnd;
          end
        end
        hfdb_pkg::PhEnd: begin
          phase_d = hfdb_pkg::PhIdle;
        end
        default: ;
      endcase
    end
  end

  // Parser results for one input transfer
  always_comb begin
    emit       = 1'b0;
    emit_kind  = hfdb_pkg::KindReply;
    emit_value = hfdb_pkg::ReplyError;
    if (s_axis_tuser_i == hfdb_pkg::ActTick) begin
      // timeout: error reply unless idle and silenced
      if (ticks_q <= 8'd1 && (phase_q != hfdb_pkg::PhIdle || idle_reports_q)) begin
        emit = 1'b1;
      end
    end else begin
      unique case (phase_q)
        hfdb_pkg::PhIdle: begin
          emit = (s_axis_tdata_i != hfdb_pkg::ByteStart);
        end
        hfdb_pkg::PhCmd: begin
          emit = 1'b1;
          if (cmd_ok) begin
            emit_kind  = hfdb_pkg::KindBreak;
            emit_value = 8'd0;
          end
        end
        hfdb_pkg::PhSlots: begin
          emit       = 1'b1;
          emit_kind  = hfdb_pkg::KindSlot;
          emit_value = s_axis_tdata_i;
        end
        hfdb_pkg::PhEnd: begin
          emit       = 1'b1;
          emit_value = (s_axis_tdata_i == hfdb_pkg::ByteEnd) ? hfdb_pkg::ReplyAck
                                                              : hfdb_pkg::ReplyError;
        end
        default: ;
      endcase
    end
  end

  // Handshakes
  assign out_fire        = res_valid_q && m_axis_tready_i;
  assign out_last        = (res_kind_q != hfdb_pkg::KindReply) || (beat_q == hfdb_pkg::BeatEnd);
  assign s_axis_tready_o = !res_valid_q || (out_fire && out_last);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hfdb_pkg::PhIdle;
      slots_q <= '0;
      ticks_q <= hfdb_pkg::TimeoutReset;
    end else if (in_fire) begin
      phase_q <= phase_d;
      slots_q <= slots_d;
      ticks_q <= ticks_d;
    end
  end

  // Result register and reply beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      beat_q      <= hfdb_pkg::BeatStart;
    end else if (in_fire) begin
      res_valid_q <= emit;
      beat_q      <= hfdb_pkg::BeatStart;
    end else if (out_fire) begin
      if (out_last) begin
        res_valid_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 2'd1;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      res_kind_q  <= emit_kind;
      res_value_q <= emit_value;
    end
  end

  // Output beat select
  always_comb begin
    m_axis_tdata_o = res_value_q;
    if (res_kind_q == hfdb_pkg::KindReply) begin
      case (beat_q)
        hfdb_pkg::BeatStart: m_axis_tdata_o = hfdb_pkg::ByteStart;
        hfdb_pkg::BeatCode:  m_axis_tdata_o = res_value_q;
        default:             m_axis_tdata_o = hfdb_pkg::ByteEnd;
      endcase
    end
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tuser_o  = res_kind_q;
  assign m_axis_tlast_o  = out_last;

endmodule

FILE: bench/host_frame_to_dmx_bridge_test.sv
// ----------------------------------------------------------------------------
// host_frame_to_dmx_bridge_test
// Self-checking bench for the host frame to DMX bridge. Host bytes and timer
// ticks are streamed in with random gaps. A cycle-free model of the frame
// parser predicts every break request, slot byte and reply byte. The result
// stream is stalled at random and checked field by field, in order.
// ----------------------------------------------------------------------------
module host_frame_to_dmx_bridge_test;

  typedef struct packed {
    hfdb_pkg::kind_e kind;
    logic [7:0]      value;
    logic            last;
  } result_t;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = '0;   // [7:0] rx_byte
  logic       s_axis_tuser_i  = 1'b0; // [0] action
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;         // [7:0] value
  logic [1:0] m_axis_tuser_o;         // [1:0] kind
  logic       m_axis_tlast_o;
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_addr_i      = 1'b0;
  logic [7:0] cfg_data_i      = '0;

  // Parser state as the bench sees it
  hfdb_pkg::phase_e frame_phase   = hfdb_pkg::PhIdle;
  logic [9:0]       slots_owed    = '0;
  logic [7:0]       ticks_left    = hfdb_pkg::TimeoutReset;
  logic [7:0]       timeout_ticks = hfdb_pkg::TimeoutReset;
  logic             idle_reports  = 1'b1;

  result_t     due_results[$];
  int unsigned mismatches = 0;

  // Idling controls for the sender and the receiver
  bit          feed_idle = 1'b1;
  bit          sink_idle = 1'b1;
  int unsigned sink_hold = 0;

  host_frame_to_dmx_bridge DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Three-byte host reply; every reply ends the frame
  function automatic void queue_reply(input logic ok);
    due_results.push_back(result_t'{hfdb_pkg::KindReply, hfdb_pkg::ByteStart, 1'b0});
    due_results.push_back(result_t'{hfdb_pkg::KindReply,
                                    ok ? hfdb_pkg::ReplyAck : hfdb_pkg::ReplyError, 1'b0});
    due_results.push_back(result_t'{hfdb_pkg::KindReply, hfdb_pkg::ByteEnd, 1'b1});
    frame_phase = hfdb_pkg::PhIdle;
  endfunction

  // Advance the parser by one accepted byte or tick
  function automatic void parse_input(input logic act, input logic [7:0] rx);
    if (act == hfdb_pkg::ActTick) begin
      if (ticks_left > 8'd1) begin
        ticks_left = ticks_left - 8'd1;
      end else begin
        // timeout: reload always, reply unless idle and silenced
        ticks_left = timeout_ticks;
        if (frame_phase != hfdb_pkg::PhIdle || idle_reports) queue_reply(1'b0);
      end
    end else begin
      ticks_left = timeout_ticks;
      case (frame_phase)
        hfdb_pkg::PhIdle: begin
          if (rx == hfdb_pkg::ByteStart) frame_phase = hfdb_pkg::PhCmd;
          else queue_reply(1'b0);
        end
        hfdb_pkg::PhCmd: begin
          if (rx inside {hfdb_pkg::Cmd96, hfdb_pkg::Cmd256, hfdb_pkg::Cmd512}) begin
            if (rx == hfdb_pkg::Cmd96) slots_owed = hfdb_pkg::Count96;
            else if (rx == hfdb_pkg::Cmd256) slots_owed = hfdb_pkg::Count256;
            else slots_owed = hfdb_pkg::Count512;
            frame_phase = (slots_owed == '0) ? hfdb_pkg::PhEnd : hfdb_pkg::PhSlots;
            due_results.push_back(result_t'{hfdb_pkg::KindBreak, 8'h00, 1'b1});
          end else begin
            queue_reply(1'b0);
          end
        end
        hfdb_pkg::PhSlots: begin
          if (slots_owed != '0) slots_owed = slots_owed - 10'd1;
          if (slots_owed == '0) frame_phase = hfdb_pkg::PhEnd;
          due_results.push_back(result_t'{hfdb_pkg::KindSlot, rx, 1'b1});
        end
        default: queue_reply(rx == hfdb_pkg::ByteEnd);
      endcase
    end
  endfunction

  // One input transfer; tvalid stays high when the next item follows at once
  task automatic send_item(input logic act, input logic [7:0] rx);
    int unsigned gap;
    gap = feed_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= rx;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    parse_input(act, rx);
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) send_item(hfdb_pkg::ActTick, 8'($urandom));
  endtask

  task automatic slot_run(input int unsigned n);
    repeat (n) send_item(hfdb_pkg::ActByte, 8'($urandom));
  endtask

  // Stop feeding, drain all awaited results, then let the parser go quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Both registers written back to back while the block is idle
  task automatic set_regs(input logic [7:0] tmo, input logic idle);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= hfdb_pkg::CfgTimeoutTicks;
    cfg_data_i  <= tmo;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    timeout_ticks = tmo;
    cfg_addr_i <= hfdb_pkg::CfgIdleReports;
    cfg_data_i <= {7'd0, idle};
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    idle_reports = idle;
    cfg_valid_i <= 1'b0;
  endtask

  // Complete frame with random channel data and the odd tick in between
  task automatic full_frame(input logic [7:0] cmd, input logic [7:0] end_byte);
    int unsigned count;
    if (cmd == hfdb_pkg::Cmd96) count = 32'(hfdb_pkg::Count96);
    else if (cmd == hfdb_pkg::Cmd256) count = 32'(hfdb_pkg::Count256);
    else count = 32'(hfdb_pkg::Count512);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    send_item(hfdb_pkg::ActByte, cmd);
    repeat (count) begin
      if ($urandom_range(0, 15) == 0) send_item(hfdb_pkg::ActTick, 8'($urandom));
      send_item(hfdb_pkg::ActByte, 8'($urandom));
    end
    send_item(hfdb_pkg::ActByte, end_byte);
  endtask

  // Bad start bytes and the timeout count left by reset
  task automatic test_idle_errors();
    send_item(hfdb_pkg::ActByte, 8'h00);
    send_item(hfdb_pkg::ActByte, 8'hFF);
    tick_run(32'(hfdb_pkg::TimeoutReset));
  endtask

  // Each command, slot extremes and rejected commands
  task automatic test_commands();
    set_regs(8'd2, 1'b1);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::Cmd96);
    send_item(hfdb_pkg::ActByte, 8'h00);
    send_item(hfdb_pkg::ActByte, 8'hFF);
    tick_run(2);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::Cmd256);
    tick_run(2);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::Cmd512);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    tick_run(2);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    send_item(hfdb_pkg::ActByte, 8'hA3);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteEnd);
  endtask

  // Timeouts in the command phase and in idle, silent idle, zero, reload and the longest count
  task automatic test_timeouts();
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    tick_run(2);
    set_regs(8'd2, 1'b0);
    tick_run(4);
    set_regs(8'd0, 1'b1);
    tick_run(2);
    set_regs(8'd3, 1'b1);
    tick_run(2);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    tick_run(3);
    // new count only applies at the next reload
    set_regs(8'd5, 1'b1);
    tick_run(2);
    set_regs(8'd1, 1'b1);
    tick_run(4);
    set_regs(8'd255, 1'b1);
    tick_run(3);
  endtask

  // Whole 96-channel frame closed by a good end byte
  task automatic test_full_frames();
    set_regs(8'd255, 1'b1);
    full_frame(hfdb_pkg::Cmd96, hfdb_pkg::ByteEnd);
  endtask

  // Receiver stalls for a long stretch while items stream in back to back
  task automatic test_backpressure();
    set_regs(8'd255, 1'b1);
    feed_idle = 1'b0;
    sink_hold = 60;
    repeat (3) send_item(hfdb_pkg::ActByte, 8'h00);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
    send_item(hfdb_pkg::ActByte, hfdb_pkg::Cmd96);
    slot_run(4);
    settle();
    feed_idle = 1'b1;
  endtask

  // Mostly frame openings with random content, cut off by ticks, plus noise
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned n;
    int unsigned ticks;
    logic [7:0]  cmd;
    for (int round = 0; round < 4; round++) begin
      set_regs(8'($urandom_range(1, 6)), 1'($urandom_range(0, 1)));
      feed_idle = round[0];
      sink_idle = (round != 2);
      sent = 0;
      while (sent < 5) begin
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 7))
            0, 1, 2: cmd = hfdb_pkg::Cmd96;
            3, 4:    cmd = hfdb_pkg::Cmd256;
            5, 6:    cmd = hfdb_pkg::Cmd512;
            default: cmd = 8'($urandom);
          endcase
          n     = $urandom_range(0, 3);
          ticks = $urandom_range(0, 6);
          send_item(hfdb_pkg::ActByte, hfdb_pkg::ByteStart);
          send_item(hfdb_pkg::ActByte, cmd);
          slot_run(n);
          tick_run(ticks);
          sent += 2 + n + ticks;
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) send_item(1'($urandom), 8'($urandom));
          sent += n;
        end
      end
    end
    feed_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Result receiver: random stalls, optional long hold, in-order checking
  initial begin : result_sink
    int unsigned pause;
    result_t     want;
    forever begin
      pause = sink_idle ? $urandom_range(0, 9) : 0;
      if (sink_hold != 0) begin
        pause     = sink_hold;
        sink_hold = 0;
      end
      if (pause != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid_o !== 1'b1);
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: kind %0d value %h last %b", $time,
                 m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tuser_o !== want.kind) begin
          $display("%0t: kind: expected %0d, actual %0d", $time, want.kind, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tdata_o !== want.value) begin
          $display("%0t: value: expected %h, actual %h", $time, want.value, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last: expected %b, actual %b", $time, want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_errors();
    test_commands();
    test_timeouts();
    test_full_frames();
    test_backpressure();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
